// File: rtl/psrw_pkg.sv
// Package for the per-source replay window: constants, scan token and tracker write types.
`default_nettype none
package psrw_pkg;

    localparam int TRACKER_COUNT_DEF = 32;
    localparam int WIN_SIZE_DEF      = 64;

    localparam int SRC_W     = 16;
    localparam int SEQ_W     = 32;
    localparam int IDX_MAX_W = 8;   // enough for the largest tracker table
    localparam int WIN_MAX_W = 64;  // widest window

    // Token that walks the tracker row, gathering the slot choice.
    typedef struct packed {
        logic                 valid;
        logic [SRC_W-1:0]     src;
        logic                 match;
        logic [IDX_MAX_W-1:0] match_idx;
        logic                 empty;
        logic [IDX_MAX_W-1:0] empty_idx;
        logic                 have_best;
        logic [SEQ_W-1:0]     best_key;
        logic [IDX_MAX_W-1:0] best_idx;
    } psrw_tok_t;

    // Broadcast update of one tracker.
    typedef struct packed {
        logic                 en;
        logic [IDX_MAX_W-1:0] idx;
        logic [SRC_W-1:0]     src;
        logic [SEQ_W-1:0]     high;
        logic [WIN_MAX_W-1:0] win;
    } psrw_wr_t;

endpackage
`default_nettype wire

// File: rtl/psrw_cell.sv
// One tracker cell: source, highest sequence and window; folds itself into the scan token.
`default_nettype none
module psrw_cell #(
    parameter int IDX      = 0,
    parameter int WIN_SIZE = psrw_pkg::WIN_SIZE_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire psrw_pkg::psrw_tok_t       tok_in,
    output psrw_pkg::psrw_tok_t            tok_out,
    input  wire psrw_pkg::psrw_wr_t        wr,
    output logic [psrw_pkg::SRC_W-1:0]     src_q,
    output logic [psrw_pkg::SEQ_W-1:0]     high_q,
    output logic [WIN_SIZE-1:0]            win_q
);
    import psrw_pkg::*;

    logic [SRC_W-1:0]       src_reg;
    logic [SEQ_W-1:0]       high_reg;
    logic [WIN_SIZE-1:0]    win_reg;
    psrw_tok_t              tok_reg;
    psrw_tok_t              tok_next;
    logic [SEQ_W-1:0]       key;

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(IDX);

    assign key = high_reg + SEQ_W'(1);

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.match && (src_reg == tok_in.src))
        begin
            tok_next.match     = 1'b1;
            tok_next.match_idx = MY_IDX;
        end
        if (!tok_in.empty && (src_reg == '0))
        begin
            tok_next.empty     = 1'b1;
            tok_next.empty_idx = MY_IDX;
        end
        if (!tok_in.have_best || (key < tok_in.best_key))
        begin
            tok_next.have_best = 1'b1;
            tok_next.best_key  = key;
            tok_next.best_idx  = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg  <= '0;
            high_reg <= '0;
            win_reg  <= '0;
            tok_reg  <= '0;
        end
        else
        begin
            if (wr.en && (wr.idx == MY_IDX))
            begin
                src_reg  <= wr.src;
                high_reg <= wr.high;
                win_reg  <= wr.win[WIN_SIZE-1:0];
            end
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;
    assign src_q   = src_reg;
    assign high_q  = high_reg;
    assign win_q   = win_reg;

endmodule
`default_nettype wire

// File: rtl/per_source_replay_window.sv
// Top level of the per-source replay window: control sequencer, tracker row and output register.
//
//  channel  | dir | handshake                    | content
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | src_id, sequence_req
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | is_replay
//  cfg      | in  | cfg_we                       | tracking_enable
//
// A tracked item's scan token is registered in each tracker cell in turn, one hop per
// cell, as it walks the row; the sequencer then runs select, update and output load.
// An untracked item goes straight to output load.
// One item is in flight at a time; s_axis_tready is high only when idle.
// The result sits in an output register, so a new item may be taken while it waits.
// Reset clears all trackers to empty and tracking_enable to zero.
`default_nettype none
module per_source_replay_window #(
    parameter int TRACKER_COUNT = psrw_pkg::TRACKER_COUNT_DEF,
    parameter int WIN_SIZE      = psrw_pkg::WIN_SIZE_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,   // [15:0] src_id, [47:16] sequence_req
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] is_replay, [7:1] zero
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata       // tracking_enable
);
    import psrw_pkg::*;

    localparam int IDX_W = (TRACKER_COUNT > 1) ? $clog2(TRACKER_COUNT) : 1;
    localparam int SH_W  = (WIN_SIZE > 1) ? $clog2(WIN_SIZE) : 1;
    localparam logic [WIN_SIZE-1:0] WIN_ONE = WIN_SIZE'(1);
    localparam logic [SEQ_W-1:0]    WIN_LEN = SEQ_W'(WIN_SIZE);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SEL,
        S_UPD,
        S_OUT
    } state_t;

    state_t                 state_reg, state_next;
    logic                   enable_reg;
    logic [SRC_W-1:0]       src_reg, src_next;
    logic [SEQ_W-1:0]       seq_reg, seq_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic                   claim_reg, claim_next;
    logic [SEQ_W-1:0]       high_reg, high_next;
    logic [WIN_SIZE-1:0]    win_reg, win_next;
    logic                   replay_reg, replay_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_replay_reg, out_replay_next;

    psrw_tok_t              tok [TRACKER_COUNT+1];
    logic [TRACKER_COUNT-1:0] tok_valid_vec;
    psrw_wr_t               wr;
    logic [SRC_W-1:0]       cell_src  [TRACKER_COUNT];
    logic [SEQ_W-1:0]       cell_high [TRACKER_COUNT];
    logic [WIN_SIZE-1:0]    cell_win  [TRACKER_COUNT];

    logic [SRC_W-1:0]       in_src;
    logic [SEQ_W-1:0]       in_seq;
    logic                   in_xfer;
    logic                   newer;
    logic [SEQ_W-1:0]       adv;
    logic [SEQ_W-1:0]       back;
    logic [WIN_SIZE-1:0]    back_bit;
    logic [WIN_SIZE-1:0]    upd_win;
    logic                   upd_replay;
    psrw_tok_t              tok_end;
    logic [IDX_MAX_W-1:0]   pick_idx;

    assign in_src  = s_axis_tdata[15:0];
    assign in_seq  = s_axis_tdata[47:16];
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    // scan token launch
    always_comb
    begin
        tok[0]           = '0;
        tok[0].valid     = in_xfer && enable_reg && (in_src != '0);
        tok[0].src       = in_src;
        tok[0].best_key  = '1;
    end

    genvar gi;
    generate
        for (gi = 0; gi < TRACKER_COUNT; gi++)
        begin : g_cell
            psrw_cell #(
                .IDX      (gi),
                .WIN_SIZE (WIN_SIZE)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok[gi]),
                .tok_out (tok[gi+1]),
                .wr      (wr),
                .src_q   (cell_src[gi]),
                .high_q  (cell_high[gi]),
                .win_q   (cell_win[gi])
            );
            assign tok_valid_vec[gi] = tok[gi+1].valid;
        end
    endgenerate

    assign tok_end  = tok[TRACKER_COUNT];
    assign pick_idx = tok_end.match ? tok_end.match_idx :
                      tok_end.empty ? tok_end.empty_idx : tok_end.best_idx;

    // window update
    always_comb
    begin
        newer    = (seq_reg > high_reg);
        adv      = seq_reg - high_reg;
        back     = high_reg - seq_reg;
        back_bit = WIN_ONE << back[SH_W-1:0];
        upd_win  = win_reg;
        upd_replay = 1'b0;
        if (newer)
        begin
            if (adv >= WIN_LEN)
                upd_win = WIN_ONE;
            else
                upd_win = (win_reg << adv[SH_W-1:0]) | WIN_ONE;
        end
        else if (back >= WIN_LEN)
            upd_replay = 1'b1;
        else if ((win_reg & back_bit) != '0)
            upd_replay = 1'b1;
        else
            upd_win = win_reg | back_bit;
    end

    always_comb
    begin
        wr.en   = (state_reg == S_UPD);
        wr.idx  = IDX_MAX_W'(slot_reg);
        wr.src  = src_reg;
        wr.high = newer ? seq_reg : high_reg;
        wr.win  = WIN_MAX_W'(upd_win);
    end

    always_comb
    begin
        state_next      = state_reg;
        src_next        = src_reg;
        seq_next        = seq_reg;
        slot_next       = slot_reg;
        claim_next      = claim_reg;
        high_next       = high_reg;
        win_next        = win_reg;
        replay_next     = replay_reg;
        out_valid_next  = out_valid_reg;
        out_replay_next = out_replay_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    src_next = in_src;
                    seq_next = in_seq;
                    if (enable_reg && (in_src != '0))
                        state_next = S_SCAN;
                    else
                    begin
                        replay_next = 1'b0;
                        state_next  = S_OUT;
                    end
                end
            end
            S_SCAN:
            begin
                if (tok_end.valid)
                begin
                    slot_next  = pick_idx[IDX_W-1:0];
                    claim_next = !tok_end.match;
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                high_next  = claim_reg ? '0 : cell_high[slot_reg];
                win_next   = claim_reg ? '0 : cell_win[slot_reg];
                state_next = S_UPD;
            end
            S_UPD:
            begin
                replay_next = upd_replay;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_replay_next = replay_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                enable_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg        <= src_next;
        seq_reg        <= seq_next;
        slot_reg       <= slot_next;
        claim_reg      <= claim_next;
        high_reg       <= high_next;
        win_reg        <= win_next;
        replay_reg     <= replay_next;
        out_replay_reg <= out_replay_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_replay_reg};

    // at most one scan token in the row
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valid_vec) <= 1)
        else $error("more than one scan token in the tracker row");

    // the row is empty whenever a new item is taken
    a_row_idle_on_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |-> (tok_valid_vec == '0))
        else $error("item taken while a scan is in progress");

    // a token reaching the end of the row is expected by the sequencer
    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_end.valid |-> (state_reg == S_SCAN))
        else $error("scan token arrived outside the scan state");

    // a matched slot really holds the item's source
    a_match_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEL && !claim_reg) |-> (cell_src[slot_reg] == src_reg))
        else $error("matched tracker does not hold the source");

    // every tracker update is followed by a result load attempt
    a_upd_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |=> (state_reg == S_OUT))
        else $error("update not followed by output stage");

endmodule
`default_nettype wire
